// ===== design/dau_pkg.sv =====
// ----------------------------------------------------------------------------
// dau_pkg
// shared widths, limits, opcodes, controller states and the command and
// status groups between controller and datapath
// ----------------------------------------------------------------------------
package dau_pkg;

  localparam int WORD_W        = 15;
  localparam int ADDR_W        = 7;
  localparam int OP_W          = 3;
  localparam int PROD_W        = 2 * WORD_W;
  localparam int MAG_W         = 14;
  localparam int DIV_STEPS     = MAG_W;
  localparam int WORD_MAX      = 9999;
  localparam int WORD_MIN      = -9999;
  localparam int MEM_WORDS_DEF = 128;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 3'd0,
    OP_FETCH = 3'd1,
    OP_ADD   = 3'd2,
    OP_SUB   = 3'd3,
    OP_MUL   = 3'd4,
    OP_DIV   = 3'd5,
    OP_MOD   = 3'd6,
    OP_POW   = 3'd7
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_FETCH,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_DIVFIN,
    S_POW,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic latch;
    logic exec;
    logic mul_fin;
    logic div_step;
    logic div_fin;
    logic pow_step;
    logic retire;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic simple;
    logic div_last;
    logic pow_end;
  } sts_t;

endpackage

// ===== design/dau_ram.sv =====
// ----------------------------------------------------------------------------
// dau_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module dau_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/dau_dp.sv =====
// ----------------------------------------------------------------------------
// dau_dp
// datapath: word memory with valid bits, accumulator, shared multiplier,
// restoring divider, power loop and the output register
// ----------------------------------------------------------------------------
module dau_dp import dau_pkg::*; #(
  parameter int MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic [OP_W-1:0]          in_op,
  input  logic [ADDR_W-1:0]        in_address,
  input  logic signed [WORD_W-1:0] in_load_value,
  output logic signed [WORD_W-1:0] out_accumulator,
  output logic signed [WORD_W-1:0] out_word_value,
  output logic                     out_ok
);

  localparam int DEPTH = (MEM_WORDS < (1 << ADDR_W)) ? MEM_WORDS : (1 << ADDR_W);
  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam logic [ADDR_W:0]             DEPTH_L  = (ADDR_W+1)'(DEPTH);
  localparam logic [CNT_W-1:0]            DIV_LAST = CNT_W'(DIV_STEPS - 1);
  localparam logic signed [WORD_W-1:0]    W_ONE    = WORD_W'(1);
  localparam logic signed [WORD_W-1:0]    W_NEG1   = WORD_W'(-1);
  localparam logic signed [WORD_W-1:0]    W_MAX    = WORD_W'(WORD_MAX);
  localparam logic signed [WORD_W-1:0]    W_MIN    = WORD_W'(WORD_MIN);
  localparam logic signed [WORD_W:0]      S_MAX    = (WORD_W+1)'(WORD_MAX);
  localparam logic signed [WORD_W:0]      S_MIN    = (WORD_W+1)'(WORD_MIN);
  localparam logic signed [PROD_W-1:0]    P_MAX    = PROD_W'(WORD_MAX);
  localparam logic signed [PROD_W-1:0]    P_MIN    = PROD_W'(WORD_MIN);

  op_t                     op_r;
  logic [ADDR_W-1:0]       addr_r;
  logic signed [WORD_W-1:0] lv_r;
  logic signed [WORD_W-1:0] acc_r;
  logic signed [WORD_W-1:0] word_r;
  logic signed [WORD_W-1:0] res_r;
  logic signed [WORD_W-1:0] res_nxt;
  logic                    ok_r;
  logic                    ok_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic [MAG_W-1:0]        rem_r;
  logic [MAG_W-1:0]        quo_r;
  logic [MAG_W-1:0]        dmag_r;
  logic [CNT_W-1:0]        dcnt_r;
  logic [MAG_W-1:0]        pcnt_r;
  logic [DEPTH-1:0]        vld_r;

  logic                    addr_ok;
  logic [AW-1:0]           idx;
  logic                    lv_ok;
  logic                    ram_we;
  logic [WORD_W-1:0]       rdata;
  logic signed [WORD_W-1:0] acc_neg;
  logic signed [WORD_W-1:0] word_neg;
  logic [MAG_W-1:0]        acc_mag;
  logic [MAG_W-1:0]        word_mag;
  logic signed [WORD_W:0]  sum;
  logic signed [WORD_W:0]  diff;
  logic                    acc_unit;
  logic                    word_zero;
  logic signed [WORD_W-1:0] pow_par;
  logic signed [WORD_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic                    prod_ok;
  logic [MAG_W:0]          trial;
  logic [MAG_W:0]          tdiff;
  logic                    ge;
  logic signed [WORD_W-1:0] q_s;
  logic signed [WORD_W-1:0] r_s;
  logic signed [WORD_W-1:0] div_res;
  logic                    simple;

  assign addr_ok   = {1'b0, addr_r} < DEPTH_L;
  assign idx       = addr_r[AW-1:0];
  assign lv_ok     = (lv_r > W_MIN) && (lv_r < W_MAX);
  assign ram_we    = cmd.exec && (op_r == OP_LOAD) && addr_ok && lv_ok;

  dau_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (lv_r),
    .raddr (idx),
    .rdata (rdata)
  );

  assign acc_neg   = -acc_r;
  assign word_neg  = -word_r;
  assign acc_mag   = acc_r[WORD_W-1] ? acc_neg[MAG_W-1:0] : acc_r[MAG_W-1:0];
  assign word_mag  = word_r[WORD_W-1] ? word_neg[MAG_W-1:0] : word_r[MAG_W-1:0];
  assign sum       = {acc_r[WORD_W-1], acc_r} + {word_r[WORD_W-1], word_r};
  assign diff      = {acc_r[WORD_W-1], acc_r} - {word_r[WORD_W-1], word_r};
  assign acc_unit  = (acc_r == W_ONE) || (acc_r == W_NEG1) || (acc_r == '0);
  assign word_zero = (word_r == '0);
  assign pow_par   = word_r[0] ? W_NEG1 : W_ONE;

  // one multiplier, shared by mul and the power loop
  assign mul_b     = cmd.pow_step ? prod_r[WORD_W-1:0] : word_r;
  assign mul_p     = PROD_W'(acc_r) * PROD_W'(mul_b);
  assign prod_ok   = (prod_r >= P_MIN) && (prod_r <= P_MAX);

  // restoring divide step on magnitudes
  assign trial     = {rem_r, quo_r[MAG_W-1]};
  assign tdiff     = trial - {1'b0, dmag_r};
  assign ge        = trial >= {1'b0, dmag_r};

  assign q_s       = {1'b0, quo_r};
  assign r_s       = {1'b0, rem_r};

  always_comb begin
    if (op_r == OP_MOD) begin
      div_res = acc_r[WORD_W-1] ? -r_s : r_s;
    end else begin
      div_res = (acc_r[WORD_W-1] ^ word_r[WORD_W-1]) ? -q_s : q_s;
    end
  end

  always_comb begin
    simple = !addr_ok
          || (op_r == OP_LOAD) || (op_r == OP_FETCH)
          || (op_r == OP_ADD) || (op_r == OP_SUB)
          || (((op_r == OP_DIV) || (op_r == OP_MOD) || (op_r == OP_POW)) && word_zero)
          || ((op_r == OP_POW) && (word_r[WORD_W-1] || acc_unit));
  end

  // outcome of the simple cases
  always_comb begin
    res_nxt = acc_r;
    ok_nxt  = 1'b0;
    if (addr_ok) begin
      unique case (op_r)
        OP_LOAD: begin
          ok_nxt = lv_ok;
        end
        OP_FETCH: begin
          res_nxt = word_r;
          ok_nxt  = 1'b1;
        end
        OP_ADD: begin
          res_nxt = sum[WORD_W-1:0];
          ok_nxt  = (sum >= S_MIN) && (sum <= S_MAX);
        end
        OP_SUB: begin
          res_nxt = diff[WORD_W-1:0];
          ok_nxt  = (diff >= S_MIN) && (diff <= S_MAX);
        end
        OP_POW: begin
          if (!word_zero) begin
            if (word_r[WORD_W-1]) begin
              if (acc_r == W_ONE) begin
                res_nxt = W_ONE;
                ok_nxt  = 1'b1;
              end else if (acc_r == W_NEG1) begin
                res_nxt = pow_par;
                ok_nxt  = 1'b1;
              end else if (acc_r != '0) begin
                res_nxt = '0;
                ok_nxt  = 1'b1;
              end
            end else if (acc_unit) begin
              res_nxt = (acc_r == W_NEG1) ? pow_par : acc_r;
              ok_nxt  = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign sts.op       = op_r;
  assign sts.simple   = simple;
  assign sts.div_last = (dcnt_r == DIV_LAST);
  assign sts.pow_end  = !prod_ok || (pcnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      vld_r <= '0;
    end else begin
      if (ram_we) begin
        vld_r[idx] <= 1'b1;
      end
      if (cmd.retire && ok_r) begin
        acc_r <= res_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= op_t'(in_op);
      addr_r <= in_address;
      lv_r   <= in_load_value;
    end
    if (cmd.latch) begin
      word_r <= (addr_ok && vld_r[idx]) ? rdata : '0;
    end
    if (cmd.exec) begin
      res_r <= res_nxt;
      ok_r  <= ok_nxt;
      if (ram_we) begin
        word_r <= lv_r;
      end
      if (op_r == OP_POW) begin
        prod_r <= PROD_W'(acc_r);
      end else begin
        prod_r <= mul_p;
      end
      pcnt_r <= word_r[MAG_W-1:0] - MAG_W'(1);
      rem_r  <= '0;
      quo_r  <= acc_mag;
      dmag_r <= word_mag;
      dcnt_r <= '0;
    end
    if (cmd.mul_fin) begin
      res_r <= prod_r[WORD_W-1:0];
      ok_r  <= prod_ok;
    end
    if (cmd.div_step) begin
      rem_r  <= ge ? tdiff[MAG_W-1:0] : trial[MAG_W-1:0];
      quo_r  <= {quo_r[MAG_W-2:0], ge};
      dcnt_r <= dcnt_r + CNT_W'(1);
    end
    if (cmd.div_fin) begin
      res_r <= div_res;
      ok_r  <= 1'b1;
    end
    if (cmd.pow_step) begin
      if (!prod_ok) begin
        ok_r <= 1'b0;
      end else if (pcnt_r == '0) begin
        res_r <= prod_r[WORD_W-1:0];
        ok_r  <= 1'b1;
      end else begin
        prod_r <= mul_p;
        pcnt_r <= pcnt_r - MAG_W'(1);
      end
    end
    if (cmd.retire) begin
      out_accumulator <= ok_r ? res_r : acc_r;
      out_word_value  <= word_r;
      out_ok          <= ok_r;
    end
  end

endmodule

// ===== design/dau_ctrl.sv =====
// ----------------------------------------------------------------------------
// dau_ctrl
// controller: sequences one instruction through read, execute and the
// multi-cycle units, and owns both handshakes
// ----------------------------------------------------------------------------
module dau_ctrl import dau_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ:  state_nxt = S_FETCH;
      S_FETCH: state_nxt = S_EXEC;
      S_EXEC: begin
        if (sts.simple) begin
          state_nxt = S_DONE;
        end else begin
          unique case (sts.op) inside
            OP_MUL:         state_nxt = S_MUL;
            OP_DIV, OP_MOD: state_nxt = S_DIV;
            default:        state_nxt = S_POW;
          endcase
        end
      end
      S_MUL: state_nxt = S_DONE;
      S_DIV: begin
        if (sts.div_last) begin
          state_nxt = S_DIVFIN;
        end
      end
      S_DIVFIN: state_nxt = S_DONE;
      S_POW: begin
        if (sts.pow_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:   cmd.capture  = in_valid;
      S_FETCH:  cmd.latch    = 1'b1;
      S_EXEC:   cmd.exec     = 1'b1;
      S_MUL:    cmd.mul_fin  = 1'b1;
      S_DIV:    cmd.div_step = 1'b1;
      S_DIVFIN: cmd.div_fin  = 1'b1;
      S_POW:    cmd.pow_step = 1'b1;
      S_DONE:   cmd.retire   = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.retire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== design/decimal_accumulator_alu.sv =====
// ----------------------------------------------------------------------------
// decimal_accumulator_alu
// accumulator instruction unit over a memory of signed four-digit words
//
// in_* carries one instruction word (op, address, load value), out_* one
// result word (accumulator, memory word at address, ok). a word moves on a
// rising edge with valid high and stall low on that channel.
// one instruction at a time: in_stall is low only while the controller idles.
// load, fetch, add, sub, a zero divisor or exponent, and power with a
// negative exponent or a base of 0 or +-1 go from execute straight to
// done; mul passes through the multiply state; div and mod run the 14-step
// restoring divider and a finishing state; other power makes one
// shared-multiplier pass per step until the exponent runs out or the value
// leaves the four-digit range. the controller returns to idle in between.
// the result sits in an output register: a stalled receiver holds it there
// while the next instruction is already taken and worked on; that one then
// waits in its last state until the register frees.
// reset clears the accumulator, the word valid bits (every word reads as zero
// until loaded) and both handshakes; no clearing pass is needed.
// ----------------------------------------------------------------------------
module decimal_accumulator_alu import dau_pkg::*; #(
  parameter int MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OP_W-1:0]          in_op,
  input  logic [ADDR_W-1:0]        in_address,
  input  logic signed [WORD_W-1:0] in_load_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WORD_W-1:0] out_accumulator,
  output logic signed [WORD_W-1:0] out_word_value,
  output logic                     out_ok
);

  cmd_t cmd;
  sts_t sts;

  dau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  dau_dp #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_op),
    .in_address      (in_address),
    .in_load_value   (in_load_value),
    .out_accumulator (out_accumulator),
    .out_word_value  (out_word_value),
    .out_ok          (out_ok)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an instruction is in flight");

  a_retire_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.retire |-> (!out_valid || !out_stall))
    else $error("result overwrote a stalled word");

  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_accumulator >= WORD_MIN && out_accumulator <= WORD_MAX))
    else $error("accumulator outside four-digit range");

  a_word_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word_value > WORD_MIN && out_word_value < WORD_MAX))
    else $error("memory word outside load range");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// instruction-level check of decimal_accumulator_alu
//
// directed programs hit the four-digit limits, zero divisors and exponents
// and negative-exponent and overflowing power, then a random program over a
// small hot set of words runs with bursty gaps on the instruction side and
// bursty stalls on the result side, ending with a stretch at full rate. a
// shadow copy of the accumulator and memory predicts every result word,
// which is checked field by field in order.
// ----------------------------------------------------------------------------
module tb;
  import dau_pkg::*;

  typedef struct {
    logic signed [WORD_W-1:0] acc;
    logic signed [WORD_W-1:0] word;
    logic                     ok;
  } result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [OP_W-1:0]          in_op;
  logic [ADDR_W-1:0]        in_address;
  logic signed [WORD_W-1:0] in_load_value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [WORD_W-1:0] out_accumulator;
  logic signed [WORD_W-1:0] out_word_value;
  logic                     out_ok;

  logic signed [WORD_W-1:0] mem_image [MEM_WORDS_DEF];
  logic signed [WORD_W-1:0] acc_image;
  result_t                  pending_results [$];
  result_t                  want;
  bit                       idle_on;
  int                       fail_count;

  decimal_accumulator_alu dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_address     (in_address),
    .in_load_value  (in_load_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_accumulator(out_accumulator),
    .out_word_value (out_word_value),
    .out_ok         (out_ok)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("decimal_accumulator_alu: mismatch");
    $finish;
  end

  function automatic bit fits_word(longint v);
    return v >= WORD_MIN && v <= WORD_MAX;
  endfunction

  function automatic bit raise_power(longint base, longint ex, output longint res);
    longint r;
    longint i;
    r = 1;
    res = 0;
    if (ex < 0) begin
      if (base == 0) return 1'b0;
      if (base == 1) res = 1;
      else if (base == -1) res = ex[0] ? -1 : 1;
      else res = 0;
      return 1'b1;
    end
    if (base == 0 || base == 1) begin
      res = base;
      return 1'b1;
    end
    if (base == -1) begin
      res = ex[0] ? -1 : 1;
      return 1'b1;
    end
    for (i = 0; i < ex; i++) begin
      r = r * base;
      if (!fits_word(r)) return 1'b0;
    end
    res = r;
    return 1'b1;
  endfunction

  function automatic result_t execute_instr(op_t op, logic [ADDR_W-1:0] addr,
                                            logic signed [WORD_W-1:0] lv);
    result_t res;
    longint  a;
    longint  w;
    longint  r;
    bit      good;
    a = acc_image;
    w = mem_image[addr];
    r = 0;
    good = 1'b0;
    case (op)
      OP_LOAD: begin
        if (lv > WORD_MIN && lv < WORD_MAX) begin
          mem_image[addr] = lv;
          good = 1'b1;
        end
      end
      OP_FETCH: begin
        r = w;
        good = 1'b1;
      end
      OP_ADD: begin
        r = a + w;
        good = fits_word(r);
      end
      OP_SUB: begin
        r = a - w;
        good = fits_word(r);
      end
      OP_MUL: begin
        r = a * w;
        good = fits_word(r);
      end
      OP_DIV: begin
        if (w != 0) begin
          r = a / w;
          good = fits_word(r);
        end
      end
      OP_MOD: begin
        if (w != 0) begin
          r = a % w;
          good = fits_word(r);
        end
      end
      default: begin
        if (w != 0) begin
          good = raise_power(a, w, r);
          good = good && fits_word(r);
        end
      end
    endcase
    if (good && op != OP_LOAD) acc_image = r[WORD_W-1:0];
    res.acc = acc_image;
    res.word = mem_image[addr];
    res.ok = good;
    return res;
  endfunction

  // drive at the falling edge, hold until taken, leave at the next falling edge
  task automatic send_instr(op_t op, int addr, int lv);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_address    <= addr[ADDR_W-1:0];
    in_load_value <= lv[WORD_W-1:0];
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_results.push_back(execute_instr(op, addr[ADDR_W-1:0], lv[WORD_W-1:0]));
    @(negedge clk);
  endtask

  function automatic int pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return int'($urandom_range(0, 40)) - 20;
      3, 4:    return int'($urandom_range(0, 198)) - 99;
      5: begin
        case ($urandom_range(0, 5))
          0:       return WORD_MAX - 1;
          1:       return WORD_MIN + 1;
          2:       return WORD_MAX;
          3:       return WORD_MIN;
          4:       return 1;
          default: return -1;
        endcase
      end
      default: return int'($urandom_range(0, 19998)) - WORD_MAX;
    endcase
  endfunction

  function automatic int pick_address();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, MEM_WORDS_DEF - 1);
    return $urandom_range(0, 11);
  endfunction

  function automatic op_t pick_op();
    int r;
    r = $urandom_range(0, 10);
    if (r > 7) return OP_LOAD;
    return op_t'(r);
  endfunction

  // unwritten words read as zero
  task automatic test_zero_operands();
    send_instr(OP_FETCH, 5, 0);
    send_instr(OP_POW, 5, 0);
    send_instr(OP_DIV, 5, 0);
    send_instr(OP_MOD, 5, 0);
  endtask

  task automatic test_range_limits();
    send_instr(OP_LOAD, 0, WORD_MAX - 1);
    send_instr(OP_LOAD, 2, WORD_MAX);
    send_instr(OP_LOAD, 3, WORD_MIN);
    send_instr(OP_LOAD, 1, WORD_MIN + 1);
    send_instr(OP_FETCH, 0, 0);
    send_instr(OP_ADD, 0, 0);
    send_instr(OP_SUB, 1, 0);
    send_instr(OP_FETCH, 1, 0);
    send_instr(OP_LOAD, 127, 1);
    send_instr(OP_SUB, 127, 0);
    send_instr(OP_ADD, 1, 0);
    send_instr(OP_LOAD, 6, -13);
    send_instr(OP_MOD, 6, 0);
  endtask

  task automatic test_power_cases();
    send_instr(OP_LOAD, 9, -1);
    send_instr(OP_POW, 9, 0);
    send_instr(OP_POW, 9, 0);
    send_instr(OP_FETCH, 9, 0);
    send_instr(OP_POW, 6, 0);
    send_instr(OP_FETCH, 127, 0);
    send_instr(OP_POW, 9, 0);
    send_instr(OP_LOAD, 12, 10);
    send_instr(OP_FETCH, 12, 0);
    send_instr(OP_POW, 12, 0);
    send_instr(OP_MUL, 12, 0);
  endtask

  task automatic test_random_program(int count);
    op_t op;
    int  addr;
    for (int i = 0; i < count; i++) begin
      op = pick_op();
      addr = pick_address();
      // small exponents keep power away from the range limit now and then
      if (op == OP_POW && $urandom_range(0, 2) == 0) begin
        send_instr(OP_LOAD, addr, int'($urandom_range(0, 12)) - 3);
        send_instr(OP_FETCH, pick_address(), 0);
      end
      send_instr(op, addr, pick_value());
    end
  endtask

  initial begin
    int guard;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_LOAD;
    in_address = '0;
    in_load_value = '0;
    idle_on = 1'b0;
    fail_count = 0;
    acc_image = '0;
    foreach (mem_image[i]) mem_image[i] = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    idle_on = 1'b1;
    test_zero_operands();
    test_range_limits();
    test_power_cases();
    test_random_program(800);
    idle_on = 1'b0;
    test_random_program(160);
    in_valid <= 1'b0;

    guard = 0;
    while (pending_results.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, pending_results.size());
      fail_count += pending_results.size();
    end
    if (fail_count == 0) begin
      $display("decimal_accumulator_alu: match");
    end else begin
      $display("decimal_accumulator_alu: mismatch");
    end
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word acc %0d word %0d ok %0b", $time,
                 out_accumulator, out_word_value, out_ok);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_accumulator !== want.acc) begin
          $display("%0t: accumulator expected %0d got %0d", $time, want.acc, out_accumulator);
          fail_count++;
        end
        if (out_word_value !== want.word) begin
          $display("%0t: word_value expected %0d got %0d", $time, want.word, out_word_value);
          fail_count++;
        end
        if (out_ok !== want.ok) begin
          $display("%0t: ok expected %0b got %0b", $time, want.ok, out_ok);
          fail_count++;
        end
      end
    end
  end

endmodule
